>>> hdl/ioc_pkg.sv
// ----------------------------------------------------------------------------
// ioc_pkg: shared types and constants
// Widths, sequencer states, register indexes and saturation helpers for the
// IMU offset calibration and smoothing block.
// ----------------------------------------------------------------------------
package ioc_pkg;

	localparam int RAW_W   = 16;
	localparam int OUT_W   = 25;
	localparam int SM_W    = 26;
	localparam int SUM_W   = 23;
	localparam int REFV_W  = 18;
	localparam int CNT_W   = 6;
	localparam int DIV_W   = 31;
	localparam int CFG_W   = 16;
	localparam int CFGI_W  = 3;
	localparam int AX      = 6;

	typedef enum logic [CFGI_W-1:0] {
		CFG_ALPHA = 3'd0,
		CFG_STILL = 3'd1,
		CFG_TILT  = 3'd2,
		CFG_GRAV  = 3'd3,
		CFG_DECIM = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		GCAL_NONE = 2'd0,
		GCAL_SAVE = 2'd1,
		GCAL_ONLY = 2'd2
	} gcal_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CAL, ST_BSEL, ST_BWAIT, ST_REFV, ST_ZSEL, ST_ZWAIT,
		ST_ZMUL0, ST_ZMUL1, ST_ZMUL2, ST_ZMUL3, ST_ZSTART, ST_ZROOT,
		ST_FMUL, ST_FADD, ST_DONE
	} state_t;

	function automatic logic signed [OUT_W-1:0] sat25(input logic signed [32:0] x);
		logic signed [32:0] hi;
		logic signed [32:0] lo;
		hi = 33'sd16777215;
		lo = -33'sd16777216;
		if (x > hi)
			return hi[OUT_W-1:0];
		else if (x < lo)
			return lo[OUT_W-1:0];
		else
			return x[OUT_W-1:0];
	endfunction

endpackage

>>> hdl/ioc_div.sv
// ----------------------------------------------------------------------------
// ioc_div: divider by a fixed calibration length
// Unsigned quotient of a wide dividend by a constant divisor, using a scaled
// reciprocal, a two-part product and one correction step.
// ----------------------------------------------------------------------------
module ioc_div #(
	parameter int W = 31,
	parameter int D = 50
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quotient
);

	// The reciprocal is scaled by 2^32, so the estimate is never more than one low.
	localparam logic [32:0]  RECIP   = 33'((64'd1 << 32) / 64'(D));
	localparam logic [W-1:0] DIVISOR = W'(D);
	localparam int           HW      = W - 16;

	logic           busy_q;
	logic           done_q;
	logic [1:0]     step_q;
	logic [W-1:0]   num_q;
	logic [W-1:0]   quo_q;
	logic [63:0]    prod_q;
	logic [48:0]    prod_lo;
	logic [HW+32:0] prod_hi;
	logic [W-1:0]   rem_c;

	assign prod_lo = num_q[15:0] * RECIP;
	assign prod_hi = num_q[W-1:16] * RECIP;
	assign rem_c   = num_q - W'(quo_q * DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
		end else if (busy_q) begin
			unique case (step_q)
				2'd0: prod_q <= 64'(prod_lo);
				2'd1: prod_q <= prod_q + 64'({prod_hi, 16'h0000});
				2'd2: quo_q  <= prod_q[32 +: W];
				2'd3: if (rem_c >= DIVISOR) quo_q <= quo_q + 1'b1;
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/ioc_isqrt.sv
// ----------------------------------------------------------------------------
// ioc_isqrt: iterative integer square root
// Floor square root of a 32-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module ioc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [15:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [31:0] rad_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [19:0] rem_sh;
	logic [19:0] trial;
	logic        ge;

	assign rem_sh = {rem_q, rad_q[31:30]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[29:0], 2'b00};
			rem_q  <= ge ? 18'(rem_sh - trial) : rem_sh[17:0];
			root_q <= {root_q[14:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hdl/imu_offset_calib_lowpass.sv
// ----------------------------------------------------------------------------
// imu_offset_calib_lowpass: IMU bias calibration and smoothing
// Averages gyro and accelerometer biases over still samples, recalibrates the
// Z accelerometer against gravity and smooths each offset-corrected axis.
// ----------------------------------------------------------------------------
// One sample is taken while in_stall is low; the block then stalls its input
// until the result is loaded into the output register, and takes the next
// sample in the cycle after that. A plain sample passes one calibration step,
// a scan of the axes for finished bias sums, one correction step, six passes
// of the shared multiplier for the smoothing filters and a final step to hand
// the beat over. Each axis whose bias calibration finishes adds a run of the
// shared reciprocal divider. A sample that finishes the Z recalibration adds
// three divisions, a select step, the multiplier steps ZMUL0 to ZMUL3 and the
// start and run of the square root. A stalled output register holds the block
// in its last step until the beat leaves.
module imu_offset_calib_lowpass import ioc_pkg::*; #(
	parameter int CALIB_SAMPLES = 50
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFGI_W-1:0]        cfg_idx,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [RAW_W-1:0]  acc_x,
	input  logic signed [RAW_W-1:0]  acc_y,
	input  logic signed [RAW_W-1:0]  acc_z,
	input  logic signed [RAW_W-1:0]  gyro_x,
	input  logic signed [RAW_W-1:0]  gyro_y,
	input  logic signed [RAW_W-1:0]  gyro_z,
	input  logic [1:0]               start_gyro_cal,
	input  logic                     start_acc_cal,
	input  logic                     start_accz_cal,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  filt_gyro_x,
	output logic signed [OUT_W-1:0]  filt_gyro_y,
	output logic signed [OUT_W-1:0]  filt_gyro_z,
	output logic signed [OUT_W-1:0]  filt_acc_x,
	output logic signed [OUT_W-1:0]  filt_acc_y,
	output logic signed [OUT_W-1:0]  filt_acc_z,
	output logic                     is_still,
	output logic                     gyro_cal_busy,
	output logic                     acc_cal_busy,
	output logic                     save_gyro_pulse,
	output logic                     save_acc_pulse
);

	localparam logic [CNT_W-1:0] NSAMP = CNT_W'(CALIB_SAMPLES);

	// configuration
	logic [8:0]               alpha_q;
	logic [14:0]              limit_q;
	logic signed [15:0]       tilt_q;
	logic [14:0]              grav_q;
	logic [7:0]               decim_q;

	// calibration and filter state
	state_t                   state_q, state_d;
	logic [3:0]               pend_q;
	logic [7:0]               dec_q;
	logic [CNT_W-1:0]         cnt_g_q, cnt_a_q, cnt_z_q;
	logic signed [SUM_W-1:0]  bsum_q [AX];
	logic signed [SUM_W-1:0]  gsum_q [3];
	logic signed [OUT_W-1:0]  off_q  [AX];
	logic signed [SM_W-1:0]   sm_q   [AX];
	logic signed [RAW_W-1:0]  prev_q [AX];
	logic [AX-1:0]            mask_q;
	logic                     zfin_q;
	logic                     still_q;
	logic                     save_g_q, save_a_q;
	logic [2:0]               k_q;
	logic                     div_neg_q;

	// working payload
	logic signed [RAW_W-1:0]  cur_q  [AX];
	logic signed [REFV_W-1:0] refv_q [AX];
	logic signed [RAW_W-1:0]  avg_q  [3];
	logic signed [43:0]       mul_q;
	logic signed [33:0]       sq_q;
	logic signed [33:0]       d_q;

	// output register
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  filt_q [AX];
	logic                     o_still_q, o_gbusy_q, o_abusy_q, o_saveg_q, o_savea_q;

	// sequencer outputs
	logic                     div_start, sq_start;
	logic signed [26:0]       mul_a;
	logic signed [16:0]       mul_b;

	logic                     in_acc, out_free;
	logic [3:0]               pend_new;

	// stillness and tilt from the previous sample
	logic                     still_c, clr_c, hit_c;
	logic [7:0]               dec_inc;
	logic [CNT_W-1:0]         cnt_g_n, cnt_a_n;
	logic signed [SUM_W-1:0]  bsum_base [AX];
	logic signed [SUM_W-1:0]  bsum_add  [AX];
	logic [16:0]              gabs [3];

	// offset-corrected sample
	logic signed [REFV_W-1:0] refv_c [AX];
	logic signed [25:0]       tdiff  [AX];
	logic [CNT_W-1:0]         cnt_z_n;

	// divider and root
	logic signed [DIV_W-1:0]  div_val;
	logic [DIV_W-1:0]         div_mag, div_quo;
	logic signed [31:0]       quo_s;
	logic                     div_busy, div_done, sq_done;
	logic [15:0]              sq_root;
	logic [31:0]              radicand;
	logic signed [26:0]       err_c;
	logic [9:0]               alpha_eff;
	logic signed [17:0]       zdiff;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		pend_new = pend_q;
		if (start_gyro_cal == GCAL_SAVE || start_gyro_cal == GCAL_ONLY)
			pend_new[1:0] = start_gyro_cal;
		if (start_acc_cal)
			pend_new[2] = 1'b1;
		if (start_accz_cal)
			pend_new[3] = 1'b1;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gabs[i] = prev_q[i][RAW_W-1] ? 17'(-{prev_q[i][RAW_W-1], prev_q[i]})
			                             : {1'b0, prev_q[i]};
		end
		still_c = (gabs[0] <= {2'b00, limit_q}) && (gabs[1] <= {2'b00, limit_q})
		       && (gabs[2] <= {2'b00, limit_q});
		clr_c   = !still_c || (prev_q[5] < tilt_q);
		dec_inc = dec_q + 8'd1;
		hit_c   = dec_inc >= decim_q;
		cnt_g_n = (clr_c ? '0 : cnt_g_q) + 1'b1;
		cnt_a_n = (clr_c ? '0 : cnt_a_q) + 1'b1;
		for (int i = 0; i < AX; i++) begin
			bsum_base[i] = clr_c ? '0 : bsum_q[i];
		end
		for (int i = 0; i < 5; i++) begin
			bsum_add[i] = SUM_W'(bsum_base[i] + SUM_W'(prev_q[i]));
		end
		bsum_add[5] = SUM_W'(bsum_base[5] + SUM_W'(prev_q[5]) - SUM_W'({1'b0, grav_q}));
	end

	// corrected sample: raw minus offset, truncated toward zero
	always_comb begin
		for (int i = 0; i < AX; i++) begin
			tdiff[i]  = 26'($signed({cur_q[i], 8'h00})) - 26'(off_q[i]);
			refv_c[i] = REFV_W'(tdiff[i] >>> 8);
			if (tdiff[i][25] && tdiff[i][7:0] != 8'h00)
				refv_c[i] = refv_c[i] + 1'b1;
		end
		cnt_z_n = cnt_z_q + 1'b1;
	end

	// shared divider operand
	always_comb begin
		if (state_q == ST_ZSEL)
			div_val = DIV_W'(gsum_q[k_q[1:0]]);
		else
			div_val = {bsum_q[k_q], 8'h00};
		div_mag = div_val[DIV_W-1] ? DIV_W'(-div_val) : div_val;
		quo_s   = div_neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	end

	assign alpha_eff = (alpha_q > 9'd256) ? 10'd256 : {1'b0, alpha_q};
	assign err_c     = 27'($signed({refv_q[k_q], 8'h00})) - 27'(sm_q[k_q]);
	assign radicand  = (d_q > 0) ? d_q[31:0] : 32'd0;
	assign zdiff     = 18'(avg_q[2]) - 18'({1'b0, sq_root});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_CAL;
			ST_CAL:    state_d = ST_BSEL;
			ST_BSEL:   begin
				if (k_q == 3'd6)
					state_d = ST_REFV;
				else if (mask_q[k_q])
					state_d = ST_BWAIT;
			end
			ST_BWAIT:  if (div_done) state_d = ST_BSEL;
			ST_REFV:   state_d = (pend_q[3] && cnt_z_n >= NSAMP) ? ST_ZSEL : ST_FMUL;
			ST_ZSEL:   state_d = (k_q == 3'd3) ? ST_ZMUL0 : ST_ZWAIT;
			ST_ZWAIT:  if (div_done) state_d = ST_ZSEL;
			ST_ZMUL0:  state_d = ST_ZMUL1;
			ST_ZMUL1:  state_d = ST_ZMUL2;
			ST_ZMUL2:  state_d = ST_ZMUL3;
			ST_ZMUL3:  state_d = ST_ZSTART;
			ST_ZSTART: state_d = ST_ZROOT;
			ST_ZROOT:  if (sq_done) state_d = ST_FMUL;
			ST_FMUL:   state_d = ST_FADD;
			ST_FADD:   state_d = (k_q == 3'd5) ? ST_DONE : ST_FMUL;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_start = 1'b0;
		sq_start  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_BSEL:   div_start = (k_q != 3'd6) && mask_q[k_q];
			ST_ZSEL:   div_start = k_q != 3'd3;
			ST_ZSTART: sq_start = 1'b1;
			ST_ZMUL0:  begin
				mul_a = 27'(avg_q[0]);
				mul_b = 17'(avg_q[0]);
			end
			ST_ZMUL1:  begin
				mul_a = 27'(avg_q[1]);
				mul_b = 17'(avg_q[1]);
			end
			ST_ZMUL2:  begin
				mul_a = 27'({1'b0, grav_q});
				mul_b = 17'({1'b0, grav_q});
			end
			ST_FMUL:   begin
				mul_a = err_c;
				mul_b = 17'(alpha_eff);
			end
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= 9'd31;
			limit_q     <= 15'd50;
			tilt_q      <= 16'sd2000;
			grav_q      <= 15'd4096;
			decim_q     <= 8'd10;
			state_q     <= ST_IDLE;
			pend_q      <= '0;
			dec_q       <= '0;
			cnt_g_q     <= '0;
			cnt_a_q     <= '0;
			cnt_z_q     <= '0;
			mask_q      <= '0;
			zfin_q      <= 1'b0;
			still_q     <= 1'b0;
			save_g_q    <= 1'b0;
			save_a_q    <= 1'b0;
			k_q         <= '0;
			div_neg_q   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < AX; i++) begin
				bsum_q[i] <= '0;
				off_q[i]  <= '0;
				sm_q[i]   <= '0;
				prev_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				gsum_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_ALPHA: alpha_q <= cfg_data[8:0];
					CFG_STILL: limit_q <= cfg_data[14:0];
					CFG_TILT:  tilt_q  <= cfg_data;
					CFG_GRAV:  grav_q  <= cfg_data[14:0];
					CFG_DECIM: decim_q <= cfg_data[7:0];
					default:   ;
				endcase
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (div_start)
				div_neg_q <= div_val[DIV_W-1];

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pend_q   <= pend_new;
						save_g_q <= 1'b0;
						save_a_q <= 1'b0;
						mask_q   <= '0;
						zfin_q   <= 1'b0;
					end
				end
				ST_CAL: begin
					still_q <= still_c;
					k_q     <= '0;
					if (pend_q != 4'd0) begin
						if (clr_c) begin
							cnt_g_q <= '0;
							cnt_a_q <= '0;
							cnt_z_q <= '0;
							for (int i = 0; i < AX; i++) bsum_q[i] <= '0;
							for (int i = 0; i < 3; i++) gsum_q[i] <= '0;
						end
						dec_q <= hit_c ? 8'd0 : dec_inc;
						if (hit_c && pend_q[1:0] != GCAL_NONE) begin
							cnt_g_q <= cnt_g_n;
							for (int i = 0; i < 3; i++) bsum_q[i] <= bsum_add[i];
							if (cnt_g_n >= NSAMP) begin
								cnt_g_q     <= '0;
								mask_q[2:0] <= 3'b111;
								save_g_q    <= pend_q[1:0] == GCAL_SAVE;
								pend_q[1:0] <= GCAL_NONE;
							end
						end
						if (hit_c && pend_q[2]) begin
							cnt_a_q <= cnt_a_n;
							for (int i = 3; i < AX; i++) bsum_q[i] <= bsum_add[i];
							if (cnt_a_n >= NSAMP) begin
								cnt_a_q     <= '0;
								mask_q[5:3] <= 3'b111;
								save_a_q    <= 1'b1;
								pend_q[2]   <= 1'b0;
							end
						end
					end
				end
				ST_BSEL: begin
					if (k_q != 3'd6 && !mask_q[k_q])
						k_q <= k_q + 1'b1;
				end
				ST_BWAIT: begin
					if (div_done) begin
						off_q[k_q]  <= sat25(33'(quo_s));
						bsum_q[k_q] <= '0;
						k_q         <= k_q + 1'b1;
					end
				end
				ST_REFV: begin
					k_q <= '0;
					if (pend_q[3]) begin
						gsum_q[0] <= SUM_W'(gsum_q[0] + SUM_W'(refv_c[3]));
						gsum_q[1] <= SUM_W'(gsum_q[1] + SUM_W'(refv_c[4]));
						gsum_q[2] <= SUM_W'(gsum_q[2] + SUM_W'(cur_q[5]));
						cnt_z_q   <= cnt_z_n;
						if (cnt_z_n >= NSAMP) begin
							cnt_z_q   <= '0;
							zfin_q    <= 1'b1;
							pend_q[3] <= 1'b0;
						end
					end
				end
				ST_ZSEL: ;
				ST_ZWAIT: begin
					if (div_done) begin
						gsum_q[k_q[1:0]] <= '0;
						k_q              <= k_q + 1'b1;
					end
				end
				ST_ZROOT: begin
					k_q <= '0;
					if (sq_done)
						off_q[5] <= sat25(33'($signed({zdiff, 8'h00})));
				end
				ST_FADD: begin
					// floor of alpha*e/256 is the arithmetic shift; the sum wraps
					sm_q[k_q] <= SM_W'(sm_q[k_q] + $signed(mul_q[33:8]));
					if (k_q != 3'd5)
						k_q <= k_q + 1'b1;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						for (int i = 0; i < AX; i++) prev_q[i] <= cur_q[i];
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (in_acc) begin
			cur_q[0] <= gyro_x;
			cur_q[1] <= gyro_y;
			cur_q[2] <= gyro_z;
			cur_q[3] <= acc_x;
			cur_q[4] <= acc_y;
			cur_q[5] <= acc_z;
		end
		if (state_q == ST_REFV) begin
			for (int i = 0; i < AX; i++) refv_q[i] <= refv_c[i];
		end
		if (state_q == ST_ZWAIT && div_done)
			avg_q[k_q[1:0]] <= quo_s[15:0];
		if (state_q == ST_ZMUL1)
			sq_q <= 34'(mul_q);
		if (state_q == ST_ZMUL2)
			sq_q <= sq_q + 34'(mul_q);
		if (state_q == ST_ZMUL3)
			d_q <= 34'(mul_q) - sq_q;
		if (state_q == ST_DONE && out_free) begin
			for (int i = 0; i < AX; i++) filt_q[i] <= sat25(33'(sm_q[i]));
			o_still_q <= still_q;
			o_gbusy_q <= pend_q[1:0] != GCAL_NONE;
			o_abusy_q <= pend_q[3:2] != 2'b00;
			o_saveg_q <= save_g_q;
			o_savea_q <= save_a_q;
		end
	end

	ioc_div #(
		.W (DIV_W),
		.D (CALIB_SAMPLES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	ioc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign out_valid       = out_valid_q;
	assign filt_gyro_x     = filt_q[0];
	assign filt_gyro_y     = filt_q[1];
	assign filt_gyro_z     = filt_q[2];
	assign filt_acc_x      = filt_q[3];
	assign filt_acc_y      = filt_q[4];
	assign filt_acc_z      = filt_q[5];
	assign is_still        = o_still_q;
	assign gyro_cal_busy   = o_gbusy_q;
	assign acc_cal_busy    = o_abusy_q;
	assign save_gyro_pulse = o_saveg_q;
	assign save_acc_pulse  = o_savea_q;

	// A gyro mode of three is never latched.
	a_gyro_mode: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q[1:0] != 2'b11) else $error("invalid gyro calibration mode");

	// Sample counters wrap before they reach the calibration length.
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (cnt_g_q < NSAMP && cnt_a_q < NSAMP && cnt_z_q < NSAMP))
		else $error("calibration counter overran");

	// The divider is only started when it is free.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");

	// A finished gyro calibration in save mode leaves no gyro request pending.
	a_save_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && save_gyro_pulse |-> !gyro_cal_busy)
		else $error("save pulse with gyro calibration still pending");

endmodule
